/* rtl/svpwm_duty_generator_unit_defines.svh */
// ----------------------------------------------------------------------------
// SVPWM duty generator assertion macros
// Concurrent checks used by the duty generator; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SVPWM_DUTY_GENERATOR_UNIT_DEFINES_SVH
`define SVPWM_DUTY_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTH
// Antecedent implies consequent in the same cycle
`define SVPWM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svpwm: assertion failed");
// Antecedent implies consequent in the next cycle
`define SVPWM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svpwm: assertion failed");
`else
`define SVPWM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SVPWM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/svpwm_pkg.sv */
// ----------------------------------------------------------------------------
// SVPWM package
// Widths, constants and stage payload types shared by the duty generator.
// ----------------------------------------------------------------------------
package svpwm_pkg;

    localparam int VOLT_BITS = 16;
    localparam int DUTY_BITS = 8;
    localparam int CFG_BITS  = 8;
    localparam int PHASES    = 3;
    localparam int Q_FRAC    = 15;

    localparam logic [DUTY_BITS-1:0] DUTY_MAX        = {DUTY_BITS{1'b1}};
    localparam logic [Q_FRAC-1:0]    SQRT3_HALF_Q15  = Q_FRAC'(28378);
    localparam logic [CFG_BITS-1:0]  DEADBAND_RESET  = CFG_BITS'(4);

    // K*b product, phase voltage (2^-15 input LSB), min+max sum, duty numerator t
    localparam int KB_W  = VOLT_BITS + Q_FRAC;
    localparam int PV_W  = VOLT_BITS + Q_FRAC + 1;
    localparam int SUM_W = PV_W + 1;
    localparam int T_W   = PV_W + 4;
    // 2 * v_bus * 2^16 for a positive bus, and t * DUTY_MAX below it
    localparam int DEN_W = VOLT_BITS + 16;
    localparam int NUM_W = DEN_W + DUTY_BITS;
    localparam int CMP_W = (DUTY_BITS > CFG_BITS) ? DUTY_BITS : CFG_BITS;

    typedef struct packed {
        logic safe;
        logic fault;
    } t_flags;

    typedef struct packed {
        logic [PHASES-1:0][PV_W-1:0] v;
        logic [VOLT_BITS-1:0]        bus;
        t_flags                      flags;
    } t_pvolt;

    typedef struct packed {
        logic [PHASES-1:0][NUM_W-1:0] num;
        logic [PHASES-1:0]            lo;
        logic [PHASES-1:0]            hi;
        logic [DEN_W-1:0]             den;
        t_flags                       flags;
    } t_num;

    typedef struct packed {
        logic [PHASES-1:0][NUM_W-1:0]     rem;
        logic [PHASES-1:0][DUTY_BITS-1:0] quo;
        logic [PHASES-1:0]                lo;
        logic [PHASES-1:0]                hi;
        logic [DEN_W-1:0]                 den;
        t_flags                           flags;
    } t_div;

endpackage

/* rtl/svpwm_if.sv */
// ----------------------------------------------------------------------------
// SVPWM channel interfaces
// Valid/ready request channels for voltage commands and duty results.
// ----------------------------------------------------------------------------
interface svpwm_in_if import svpwm_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic signed [VOLT_BITS-1:0] v_alpha;
    logic signed [VOLT_BITS-1:0] v_beta;
    logic signed [VOLT_BITS-1:0] v_bus;
    logic                        force_off;

    modport source (output valid, v_alpha, v_beta, v_bus, force_off, input ready);
    modport sink   (input valid, v_alpha, v_beta, v_bus, force_off, output ready);
endinterface

interface svpwm_out_if import svpwm_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [DUTY_BITS-1:0] phase_a_high;
    logic [DUTY_BITS-1:0] phase_a_low;
    logic [DUTY_BITS-1:0] phase_b_high;
    logic [DUTY_BITS-1:0] phase_b_low;
    logic [DUTY_BITS-1:0] phase_c_high;
    logic [DUTY_BITS-1:0] phase_c_low;
    logic                 bus_fault;

    modport source (output valid, phase_a_high, phase_a_low, phase_b_high, phase_b_low,
                    phase_c_high, phase_c_low, bus_fault, input ready);
    modport sink   (input valid, phase_a_high, phase_a_low, phase_b_high, phase_b_low,
                    phase_c_high, phase_c_low, bus_fault, output ready);
endinterface

/* rtl/svpwm_clarke.sv */
// ----------------------------------------------------------------------------
// SVPWM inverse Clarke
// Two stages: sqrt(3)/2 * beta product, then the three phase voltages.
// ----------------------------------------------------------------------------
module svpwm_clarke import svpwm_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    svpwm_in_if.sink       i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output t_pvolt         o_pv
);

    typedef struct packed {
        logic [VOLT_BITS-1:0] a;
        logic [KB_W-1:0]      kb;
        logic [VOLT_BITS-1:0] bus;
        t_flags               flags;
    } t_prod;

    logic   r_v1;
    logic   r_v2;
    t_prod  r_s1;
    t_prod  n_s1;
    t_pvolt r_s2;
    t_pvolt n_s2;
    logic   w_en1;
    logic   w_en2;

    logic signed [KB_W-1:0] w_k;
    logic signed [KB_W-1:0] w_b;
    logic signed [PV_W-1:0] w_va;
    logic signed [PV_W-1:0] w_a14;
    logic signed [PV_W-1:0] w_kb;

    assign w_en2       = !r_v2 || i_ready;
    assign w_en1       = !r_v1 || w_en2;
    assign i_cmd.ready = w_en1;

    always_comb begin
        w_k         = KB_W'($signed({1'b0, SQRT3_HALF_Q15}));
        w_b         = KB_W'(i_cmd.v_beta);
        n_s1.a      = i_cmd.v_alpha;
        n_s1.kb     = w_k * w_b;
        n_s1.bus    = i_cmd.v_bus;
        n_s1.flags.fault = i_cmd.v_bus[VOLT_BITS-1] || (i_cmd.v_bus == '0);
        n_s1.flags.safe  = n_s1.flags.fault || i_cmd.force_off;
    end

    always_comb begin
        w_va  = {{(PV_W-VOLT_BITS-Q_FRAC){r_s1.a[VOLT_BITS-1]}}, r_s1.a, {Q_FRAC{1'b0}}};
        w_a14 = {{(PV_W-VOLT_BITS-Q_FRAC+1){r_s1.a[VOLT_BITS-1]}}, r_s1.a,
                 {(Q_FRAC-1){1'b0}}};
        w_kb  = PV_W'($signed(r_s1.kb));
        n_s2.v[0]  = w_va;
        n_s2.v[1]  = w_kb - w_a14;
        n_s2.v[2]  = -w_kb - w_a14;
        n_s2.bus   = r_s1.bus;
        n_s2.flags = r_s1.flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_cmd.valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1 <= n_s1;
        end
        if (w_en2) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_v2;
    assign o_pv    = r_s2;

endmodule

/* rtl/svpwm_offset.sv */
// ----------------------------------------------------------------------------
// SVPWM min-max offset
// Three stages: min+max of the phases, duty numerator per phase, then the
// range check and the scaled numerator for the divider.
// ----------------------------------------------------------------------------
module svpwm_offset import svpwm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_pvolt i_pv,
    output logic   o_valid,
    input  logic   i_ready,
    output t_num   o_num
);

    typedef struct packed {
        logic [PHASES-1:0][PV_W-1:0] v;
        logic [SUM_W-1:0]            sum;
        logic [VOLT_BITS-1:0]        bus;
        t_flags                      flags;
    } t_sum;

    typedef struct packed {
        logic [PHASES-1:0][T_W-1:0] t;
        logic [DEN_W-1:0]           den;
        t_flags                     flags;
    } t_tval;

    logic  r_v3;
    logic  r_v4;
    logic  r_v5;
    t_sum  r_s3;
    t_sum  n_s3;
    t_tval r_s4;
    t_tval n_s4;
    t_num  r_s5;
    t_num  n_s5;
    logic  w_en3;
    logic  w_en4;
    logic  w_en5;

    logic signed [PV_W-1:0]  w_p0;
    logic signed [PV_W-1:0]  w_p1;
    logic signed [PV_W-1:0]  w_p2;
    logic signed [PV_W-1:0]  w_mx;
    logic signed [PV_W-1:0]  w_mn;
    logic signed [PV_W-1:0]  w_v;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [VOLT_BITS-1:0] w_bus;
    logic [DEN_W-1:0]        w_tl;

    assign w_en5   = !r_v5 || i_ready;
    assign w_en4   = !r_v4 || w_en5;
    assign w_en3   = !r_v3 || w_en4;
    assign o_ready = w_en3;

    always_comb begin
        w_p0 = $signed(i_pv.v[0]);
        w_p1 = $signed(i_pv.v[1]);
        w_p2 = $signed(i_pv.v[2]);
        w_mx = w_p0;
        w_mn = w_p0;
        if (w_p1 > w_mx) begin
            w_mx = w_p1;
        end
        if (w_p2 > w_mx) begin
            w_mx = w_p2;
        end
        if (w_p1 < w_mn) begin
            w_mn = w_p1;
        end
        if (w_p2 < w_mn) begin
            w_mn = w_p2;
        end
        n_s3.v     = i_pv.v;
        n_s3.sum   = SUM_W'(w_mx) + SUM_W'(w_mn);
        n_s3.bus   = i_pv.bus;
        n_s3.flags = i_pv.flags;
    end

    // t = 2 * (2v - (max + min)) + v_bus * 2^16
    always_comb begin
        w_sum = $signed(r_s3.sum);
        w_bus = $signed(r_s3.bus);
        w_v   = '0;
        for (int p = 0; p < PHASES; p++) begin
            w_v = $signed(r_s3.v[p]);
            n_s4.t[p] = (T_W'(w_v) <<< 2) - (T_W'(w_sum) <<< 1) + (T_W'(w_bus) <<< 16);
        end
        n_s4.den   = {r_s3.bus[VOLT_BITS-2:0], {(DEN_W-VOLT_BITS+1){1'b0}}};
        n_s4.flags = r_s3.flags;
    end

    // clamp at or below zero and at or above the full scale; scale the rest by DUTY_MAX
    always_comb begin
        w_tl = '0;
        for (int p = 0; p < PHASES; p++) begin
            w_tl        = r_s4.t[p][DEN_W-1:0];
            n_s5.lo[p]  = r_s4.t[p][T_W-1] || (r_s4.t[p] == '0);
            n_s5.hi[p]  = !n_s5.lo[p] && (r_s4.t[p] >= T_W'(r_s4.den));
            n_s5.num[p] = {w_tl, {DUTY_BITS{1'b0}}} - NUM_W'(w_tl);
        end
        n_s5.den   = r_s4.den;
        n_s5.flags = r_s4.flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_en3) begin
                r_v3 <= i_valid;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
            if (w_en5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3 <= n_s3;
        end
        if (w_en4) begin
            r_s4 <= n_s4;
        end
        if (w_en5) begin
            r_s5 <= n_s5;
        end
    end

    assign o_valid = r_v5;
    assign o_num   = r_s5;

endmodule

/* rtl/svpwm_divider.sv */
// ----------------------------------------------------------------------------
// SVPWM duty divider
// Restoring division of the scaled numerator by the bus term, one quotient
// bit per stage, all three phases side by side.
// ----------------------------------------------------------------------------
module svpwm_divider import svpwm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_num i_num,
    output logic o_valid,
    input  logic i_ready,
    output t_div o_div
);

    logic [DUTY_BITS-1:0] r_vld;
    logic [DUTY_BITS-1:0] w_vin;
    logic [DUTY_BITS:0]   w_en;
    t_div                 r_st  [DUTY_BITS];
    t_div                 n_st  [DUTY_BITS];
    t_div                 w_src [DUTY_BITS];
    logic [NUM_W-1:0]     w_dsh;

    always_comb begin
        w_en[DUTY_BITS] = i_ready;
        for (int g = DUTY_BITS - 1; g >= 0; g--) begin
            w_en[g] = !r_vld[g] || w_en[g+1];
        end
    end

    assign o_ready = w_en[0];
    assign w_vin   = {r_vld[DUTY_BITS-2:0], i_valid};

    always_comb begin
        w_src[0].rem   = i_num.num;
        w_src[0].quo   = '0;
        w_src[0].lo    = i_num.lo;
        w_src[0].hi    = i_num.hi;
        w_src[0].den   = i_num.den;
        w_src[0].flags = i_num.flags;
        for (int g = 1; g < DUTY_BITS; g++) begin
            w_src[g] = r_st[g-1];
        end
    end

    // stage g decides quotient bit DUTY_BITS-1-g and shifts it in from the right
    always_comb begin
        w_dsh = '0;
        for (int g = 0; g < DUTY_BITS; g++) begin
            n_st[g] = w_src[g];
            w_dsh   = NUM_W'(w_src[g].den) << (DUTY_BITS - 1 - g);
            for (int p = 0; p < PHASES; p++) begin
                if (w_src[g].rem[p] >= w_dsh) begin
                    n_st[g].rem[p] = w_src[g].rem[p] - w_dsh;
                    n_st[g].quo[p] = {w_src[g].quo[p][DUTY_BITS-2:0], 1'b1};
                end else begin
                    n_st[g].quo[p] = {w_src[g].quo[p][DUTY_BITS-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int g = 0; g < DUTY_BITS; g++) begin
                if (w_en[g]) begin
                    r_vld[g] <= w_vin[g];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < DUTY_BITS; g++) begin
            if (w_en[g]) begin
                r_st[g] <= n_st[g];
            end
        end
    end

    assign o_valid = r_vld[DUTY_BITS-1];
    assign o_div   = r_st[DUTY_BITS-1];

endmodule

/* rtl/svpwm_output.sv */
// ----------------------------------------------------------------------------
// SVPWM output stage
// Clamp, dead-time subtraction and safe-state selection into the result
// register.
// ----------------------------------------------------------------------------
module svpwm_output import svpwm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_div                i_div,
    input  logic [CFG_BITS-1:0] i_deadband,
    svpwm_out_if.source         o_duty
);

    typedef struct packed {
        logic [PHASES-1:0][DUTY_BITS-1:0] high;
        logic [PHASES-1:0][DUTY_BITS-1:0] low;
        logic                             fault;
    } t_duty;

    logic                 r_vld;
    t_duty                r_out;
    t_duty                n_out;
    logic                 w_en;
    logic [DUTY_BITS-1:0] w_d;
    logic [DUTY_BITS-1:0] w_hv;
    logic [CMP_W-1:0]     w_dx;
    logic [CMP_W-1:0]     w_tx;

    assign w_en    = !r_vld || o_duty.ready;
    assign o_ready = w_en;

    always_comb begin
        w_d  = '0;
        w_hv = '0;
        w_dx = '0;
        w_tx = CMP_W'(i_deadband);
        for (int p = 0; p < PHASES; p++) begin
            if (i_div.lo[p]) begin
                w_d = '0;
            end else if (i_div.hi[p]) begin
                w_d = DUTY_MAX;
            end else begin
                w_d = i_div.quo[p];
            end
            w_dx = CMP_W'(w_d);
            w_hv = (w_dx > w_tx) ? DUTY_BITS'(w_dx - w_tx) : '0;
            if (i_div.flags.safe) begin
                n_out.high[p] = '0;
                n_out.low[p]  = DUTY_MAX;
            end else begin
                n_out.high[p] = w_hv;
                n_out.low[p]  = w_hv;
            end
        end
        n_out.fault = i_div.flags.fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_duty.valid        = r_vld;
    assign o_duty.phase_a_high = r_out.high[0];
    assign o_duty.phase_a_low  = r_out.low[0];
    assign o_duty.phase_b_high = r_out.high[1];
    assign o_duty.phase_b_low  = r_out.low[1];
    assign o_duty.phase_c_high = r_out.high[2];
    assign o_duty.phase_c_low  = r_out.low[2];
    assign o_duty.bus_fault    = r_out.fault;

endmodule

/* rtl/svpwm_duty_generator_unit.sv */
// Request to result: Clarke, offset and divider stages, then the output register.
// Throughput: one request per cycle while the sink is ready; one bit per stage.
// Every stage holds under back-pressure and bubbles collapse, so nothing is dropped.
// Reset: synchronous, active low; clears all valid bits and sets dead time to 4 counts.
// ----------------------------------------------------------------------------
// SVPWM duty generator
// Inverse Clarke, min-max offset, duty scaling by the bus voltage, dead time
// and safe-state handling in one streaming pipeline.
// ----------------------------------------------------------------------------
`include "svpwm_duty_generator_unit_defines.svh"

module svpwm_duty_generator_unit import svpwm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    svpwm_in_if.sink            i_cmd,
    svpwm_out_if.source         o_duty,
    input  logic                i_cfg_we,
    input  logic [CFG_BITS-1:0] i_cfg_wdata
);

    logic [CFG_BITS-1:0] r_deadband;
    logic                w_pv_valid;
    logic                w_pv_ready;
    t_pvolt              w_pv;
    logic                w_num_valid;
    logic                w_num_ready;
    t_num                w_num;
    logic                w_div_valid;
    logic                w_div_ready;
    t_div                w_div;
    logic [CMP_W:0]      w_chk_a;
    logic [CMP_W:0]      w_chk_b;
    logic [CMP_W:0]      w_chk_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= DEADBAND_RESET;
        end else if (i_cfg_we) begin
            r_deadband <= i_cfg_wdata;
        end
    end

    svpwm_clarke u_clarke (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_valid (w_pv_valid),
        .i_ready (w_pv_ready),
        .o_pv    (w_pv)
    );

    svpwm_offset u_offset (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pv_valid),
        .o_ready (w_pv_ready),
        .i_pv    (w_pv),
        .o_valid (w_num_valid),
        .i_ready (w_num_ready),
        .o_num   (w_num)
    );

    svpwm_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_num_valid),
        .o_ready (w_num_ready),
        .i_num   (w_num),
        .o_valid (w_div_valid),
        .i_ready (w_div_ready),
        .o_div   (w_div)
    );

    svpwm_output u_output (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_div_valid),
        .o_ready    (w_div_ready),
        .i_div      (w_div),
        .i_deadband (r_deadband),
        .o_duty     (o_duty)
    );

    // high-side compare plus dead time never passes full scale
    assign w_chk_a = (CMP_W+1)'(o_duty.phase_a_high) + (CMP_W+1)'(r_deadband);
    assign w_chk_b = (CMP_W+1)'(o_duty.phase_b_high) + (CMP_W+1)'(r_deadband);
    assign w_chk_c = (CMP_W+1)'(o_duty.phase_c_high) + (CMP_W+1)'(r_deadband);

    `SVPWM_ASSERT_IMP(a_fault_safe, i_clk, i_rst_n, o_duty.valid && o_duty.bus_fault, (o_duty.phase_a_high == '0) && (o_duty.phase_b_high == '0) && (o_duty.phase_c_high == '0) && (o_duty.phase_a_low == DUTY_MAX) && (o_duty.phase_b_low == DUTY_MAX) && (o_duty.phase_c_low == DUTY_MAX))
    `SVPWM_ASSERT_IMP(a_side_pair, i_clk, i_rst_n, o_duty.valid, ((o_duty.phase_a_high == o_duty.phase_a_low) || ((o_duty.phase_a_high == '0) && (o_duty.phase_a_low == DUTY_MAX))) && ((o_duty.phase_b_high == o_duty.phase_b_low) || ((o_duty.phase_b_high == '0) && (o_duty.phase_b_low == DUTY_MAX))) && ((o_duty.phase_c_high == o_duty.phase_c_low) || ((o_duty.phase_c_high == '0) && (o_duty.phase_c_low == DUTY_MAX))))
    `SVPWM_ASSERT_IMP(a_deadband, i_clk, i_rst_n, o_duty.valid, ((o_duty.phase_a_high == '0) || (w_chk_a <= (CMP_W+1)'(DUTY_MAX))) && ((o_duty.phase_b_high == '0) || (w_chk_b <= (CMP_W+1)'(DUTY_MAX))) && ((o_duty.phase_c_high == '0) || (w_chk_c <= (CMP_W+1)'(DUTY_MAX))))
    `SVPWM_ASSERT_NXT(a_cfg_write, i_clk, i_rst_n, i_cfg_we, r_deadband == $past(i_cfg_wdata))

endmodule

/* tb/svpwm_duty_generator_unit_test.sv */
// ----------------------------------------------------------------------------
// SVPWM duty generator testbench
// Drives voltage-command requests through bursty traffic against a stalling
// duty sink, predicts every compare set with exact integer arithmetic and
// checks each field. Dead time is reprogrammed between idle phases.
// ----------------------------------------------------------------------------
module svpwm_duty_generator_unit_test;
    import svpwm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 24;
    localparam int RANDOM_CMDS   = 1250;

    typedef struct packed {
        logic signed [VOLT_BITS-1:0] alpha;
        logic signed [VOLT_BITS-1:0] beta;
        logic signed [VOLT_BITS-1:0] bus;
        logic                        off;
    } t_duty_cmd;

    typedef struct packed {
        logic [DUTY_BITS-1:0] a_high;
        logic [DUTY_BITS-1:0] a_low;
        logic [DUTY_BITS-1:0] b_high;
        logic [DUTY_BITS-1:0] b_low;
        logic [DUTY_BITS-1:0] c_high;
        logic [DUTY_BITS-1:0] c_low;
        logic                 fault;
    } t_duty_set;

    logic                clk;
    logic                rst_n;
    logic                cfg_we    = 1'b0;
    logic [CFG_BITS-1:0] cfg_wdata = '0;

    svpwm_in_if  cmd_if ();
    svpwm_out_if duty_if ();

    svpwm_duty_generator_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cmd       (cmd_if),
        .o_duty      (duty_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    t_duty_cmd           cmd_queue [$];
    t_duty_set           duty_expect_q [$];
    logic [CFG_BITS-1:0] deadband;
    int                  cycle_count;
    int                  fail_count;
    int                  checked_count;
    int                  fault_count;
    int                  off_count;
    int                  setting_count;
    int                  burst_left;
    int                  gap_left;
    int                  stall_mode;
    int                  stall_tick;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // One phase compare: w in 2^-15 input LSB, den = 2 * v_bus * 2^16
    function automatic logic [DUTY_BITS-1:0] phase_compare(longint w, longint den,
                                                          logic [CFG_BITS-1:0] dead);
        longint t;
        longint d;
        t = 2 * w + den / 2;
        if (t <= 0)
            d = 0;
        else if (t >= den)
            d = DUTY_MAX;
        else
            d = (t * DUTY_MAX) / den;
        if (d > dead)
            return DUTY_BITS'(d - dead);
        return '0;
    endfunction

    function automatic t_duty_set predict_duties(t_duty_cmd c, logic [CFG_BITS-1:0] dead);
        t_duty_set r;
        longint    a, b, bus, va, vb, vc, mx, mn, sum, den;
        logic [DUTY_BITS-1:0] da, db, dc;
        a   = longint'($signed(c.alpha));
        b   = longint'($signed(c.beta));
        bus = longint'($signed(c.bus));
        r.fault = (bus <= 0);
        if (r.fault || c.off) begin
            r.a_high = '0;
            r.b_high = '0;
            r.c_high = '0;
            r.a_low  = DUTY_MAX;
            r.b_low  = DUTY_MAX;
            r.c_low  = DUTY_MAX;
            return r;
        end
        va  = a * 32768;
        vb  = -(a * 16384) + longint'(SQRT3_HALF_Q15) * b;
        vc  = -(a * 16384) - longint'(SQRT3_HALF_Q15) * b;
        mx  = va;
        mn  = va;
        if (vb > mx) mx = vb;
        if (vc > mx) mx = vc;
        if (vb < mn) mn = vb;
        if (vc < mn) mn = vc;
        sum = mx + mn;
        den = bus * 131072;
        da  = phase_compare(2 * va - sum, den, dead);
        db  = phase_compare(2 * vb - sum, den, dead);
        dc  = phase_compare(2 * vc - sum, den, dead);
        r.a_high = da;
        r.a_low  = da;
        r.b_high = db;
        r.b_low  = db;
        r.c_high = dc;
        r.c_low  = dc;
        return r;
    endfunction

    function automatic logic signed [VOLT_BITS-1:0] sat_volt(int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return VOLT_BITS'(v);
    endfunction

    task automatic queue_cmd(int alpha, int beta, int bus, bit off);
        t_duty_cmd c;
        c.alpha = VOLT_BITS'(alpha);
        c.beta  = VOLT_BITS'(beta);
        c.bus   = VOLT_BITS'(bus);
        c.off   = off;
        cmd_queue.push_back(c);
    endtask

    task automatic check_field(string name, logic [DUTY_BITS-1:0] exp_v,
                               logic [DUTY_BITS-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Wait until nothing is queued, in flight or outstanding
    task automatic drain_block;
        @(negedge clk);
        while (cmd_queue.size() != 0 || cmd_if.valid || duty_expect_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_deadband(logic [CFG_BITS-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        deadband   = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        setting_count++;
    endtask

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Request driver: bursts of random length separated by random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            cmd_if.valid <= 1'b0;
            burst_left    = 0;
            gap_left      = 0;
        end else if (!cmd_if.valid || cmd_if.ready) begin
            if (gap_left > 0 || cmd_queue.size() == 0) begin
                cmd_if.valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end else begin
                t_duty_cmd c;
                c = cmd_queue.pop_front();
                cmd_if.valid     <= 1'b1;
                cmd_if.v_alpha   <= c.alpha;
                cmd_if.v_beta    <= c.beta;
                cmd_if.v_bus     <= c.bus;
                cmd_if.force_off <= c.off;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // Result sink stalls on a randomly reselected pattern
    always @(posedge clk) begin
        if (!rst_n) begin
            duty_if.ready <= 1'b0;
            stall_mode     = 0;
            stall_tick     = 0;
        end else begin
            stall_tick++;
            if (stall_tick % 97 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: duty_if.ready <= 1'b1;
                1: duty_if.ready <= 1'($urandom_range(0, 1));
                2: duty_if.ready <= (stall_tick % 3 == 0);
                default: duty_if.ready <= (stall_tick % 8 >= 6);
            endcase
        end
    end

    // Check results first, then record the prediction for a new request
    always @(posedge clk) begin
        if (rst_n) begin
            if (duty_if.valid && duty_if.ready) begin
                if (duty_expect_q.size() == 0) begin
                    $error("duty result with no request outstanding");
                    fail_count++;
                end else begin
                    t_duty_set e;
                    e = duty_expect_q.pop_front();
                    check_field("phase_a_high", e.a_high, duty_if.phase_a_high);
                    check_field("phase_a_low",  e.a_low,  duty_if.phase_a_low);
                    check_field("phase_b_high", e.b_high, duty_if.phase_b_high);
                    check_field("phase_b_low",  e.b_low,  duty_if.phase_b_low);
                    check_field("phase_c_high", e.c_high, duty_if.phase_c_high);
                    check_field("phase_c_low",  e.c_low,  duty_if.phase_c_low);
                    check_field("bus_fault", DUTY_BITS'(e.fault), DUTY_BITS'(duty_if.bus_fault));
                    checked_count++;
                    if (e.fault)
                        fault_count++;
                end
            end
            if (cmd_if.valid && cmd_if.ready) begin
                t_duty_cmd c;
                c.alpha = cmd_if.v_alpha;
                c.beta  = cmd_if.v_beta;
                c.bus   = cmd_if.v_bus;
                c.off   = cmd_if.force_off;
                if (c.off)
                    off_count++;
                duty_expect_q.push_back(predict_duties(c, deadband));
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, duty_expect_q.size());
        $display("svpwm_duty_generator_unit_test failed");
        $finish;
    end

    initial begin
        logic [CFG_BITS-1:0] dead_plan [8];
        int                  per_phase;
        int                  kind, bus, span, alpha, beta;
        bit                  off;

        fail_count    = 0;
        checked_count = 0;
        fault_count   = 0;
        off_count     = 0;
        setting_count = 1;
        deadband      = DEADBAND_RESET;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests at the reset dead time
        queue_cmd(0, 0, 256, 0);
        queue_cmd(32767, 0, 1, 0);
        queue_cmd(-32768, 0, 1, 0);
        queue_cmd(0, 32767, 1, 0);
        queue_cmd(0, -32768, 32767, 0);
        queue_cmd(-32768, -32768, 32767, 0);
        queue_cmd(32767, 32767, 32767, 0);
        queue_cmd(-32768, 32767, 16384, 0);
        queue_cmd(0, 0, 0, 0);
        queue_cmd(0, 0, -1, 0);
        queue_cmd(0, 0, -32768, 1);
        queue_cmd(100, 50, 32767, 1);
        queue_cmd(0, 0, 1, 0);
        queue_cmd(0, 0, 32767, 0);
        queue_cmd(256, 0, 256, 0);
        queue_cmd(-256, 0, 256, 0);
        queue_cmd(0, 256, 256, 0);
        queue_cmd(0, -256, 256, 0);
        queue_cmd(8, 0, 1000, 0);
        queue_cmd(-250, 3, 500, 0);
        queue_cmd(1, -1, 32767, 0);
        drain_block();

        dead_plan[0] = 8'd0;
        dead_plan[1] = 8'd255;
        dead_plan[2] = 8'd37;
        dead_plan[3] = CFG_BITS'($urandom_range(0, 255));
        dead_plan[4] = 8'd1;
        dead_plan[5] = 8'd128;
        dead_plan[6] = CFG_BITS'($urandom_range(0, 255));
        dead_plan[7] = DEADBAND_RESET;
        per_phase = RANDOM_CMDS / 8;

        foreach (dead_plan[p]) begin
            write_deadband(dead_plan[p]);
            for (int n = 0; n < per_phase; n++) begin
                kind = $urandom_range(0, 9);
                bus  = $urandom_range(0, 1) ? $urandom_range(1, 32767) : $urandom_range(1, 600);
                off  = 1'b0;
                if (kind < 6) begin
                    // commands scaled to the bus so duties land mostly in range
                    span  = bus + bus / 4 + 1;
                    alpha = sat_volt($urandom_range(0, 2 * span) - span);
                    beta  = sat_volt($urandom_range(0, 2 * span) - span);
                end else begin
                    alpha = $signed(16'($urandom));
                    beta  = $signed(16'($urandom));
                    if (kind == 8) begin
                        bus = -int'($urandom_range(0, 32768));
                        off = 1'($urandom_range(0, 1));
                    end else if (kind == 9) begin
                        off = 1'b1;
                    end
                end
                queue_cmd(alpha, beta, bus, off);
            end
            drain_block();
        end

        $display("checked %0d duty results over %0d dead-time settings",
                 checked_count, setting_count);
        $display("safe-state coverage: %0d bus faults, %0d forced off requests",
                 fault_count, off_count);
        if (fail_count == 0 && duty_expect_q.size() == 0) begin
            $display("svpwm_duty_generator_unit_test passed");
        end else begin
            $display("svpwm_duty_generator_unit_test failed");
        end
        $finish;
    end

endmodule
